// ===== rtl/core/rbei_pkg.sv =====
// ----------------------------------------------------------------------------
// rbei_pkg - random bit error injector shared definitions
// Register map codes, generator constants and the structs passed between
// the sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rbei_pkg;

	// drand48 generator: x' = (MUL * x + ADD) mod 2^48, MUL split at bit 32
	localparam logic [31:0] LCG_MUL_LO  = 32'hDEEC_E66D;
	localparam logic [2:0]  LCG_MUL_HI  = 3'h5;
	localparam logic [47:0] LCG_ADD     = 48'hB;
	localparam logic [47:0] LCG_DEFAULT = 48'h1234_ABCD_330E;
	localparam logic [47:0] SEED_RESET  = 48'd20017429951246;

	localparam logic [7:0]  MASK_MSB    = 8'h80;

	// register indexes (byte address / 8)
	localparam logic [2:0] REG_THRESHOLD  = 3'd0;
	localparam logic [2:0] REG_MAX_ERRORS = 3'd1;
	localparam logic [2:0] REG_HEADER     = 3'd2;
	localparam logic [2:0] REG_TRAILER    = 3'd3;
	localparam logic [2:0] REG_SEED       = 3'd4;

	typedef struct packed {
		logic [48:0] error_threshold;
		logic [4:0]  max_errors;
		logic [16:0] header_bits;
		logic [16:0] trailer_bits;
	} cfg_t;

	typedef struct packed {
		logic        flip;
		logic [12:0] byte_index;
		logic [7:0]  bit_mask;
		logic        zone_empty;
		logic        last_test;
		logic [31:0] errored_units;
		logic [31:0] total_flips;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DRAW,
		S_DRAW_WAIT,
		S_POS,
		S_POS_WAIT,
		S_MOD_WAIT,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbei_lcg.sv =====
// ----------------------------------------------------------------------------
// rbei_lcg - drand48 step unit
// One 24x32 multiplier reused over three partial products forms the 48-bit
// next state.
// ----------------------------------------------------------------------------
`default_nettype none

module rbei_lcg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] x,
	output logic             done,
	output logic [47:0]      result
);

	logic [47:0] x_q;
	logic [47:0] acc_q;
	logic [55:0] prod_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [23:0] mul_a;
	logic [31:0] mul_b;

	always_comb begin
		unique case (cnt_q)
			2'd0: begin
				mul_a = x_q[23:0];
				mul_b = rbei_pkg::LCG_MUL_LO;
			end
			2'd1: begin
				mul_a = x_q[47:24];
				mul_b = rbei_pkg::LCG_MUL_LO;
			end
			2'd2: begin
				mul_a = x_q[23:0];
				mul_b = {29'b0, rbei_pkg::LCG_MUL_HI};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// only the bits of each partial product that land below 2^48 are kept
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			acc_q <= rbei_pkg::LCG_ADD;
		end else if (busy_q) begin
			prod_q <= 56'(mul_a * mul_b);
			unique case (cnt_q)
				2'd1:    acc_q <= acc_q + prod_q[47:0];
				2'd2:    acc_q <= acc_q + {prod_q[23:0], 24'b0};
				2'd3:    acc_q <= acc_q + {prod_q[15:0], 32'b0};
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbei_mod.sv =====
// ----------------------------------------------------------------------------
// rbei_mod - bit-serial remainder unit
// Restoring division of a 31-bit value by a 17-bit zone size, one quotient
// bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module rbei_mod (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [30:0] dividend,
	input  wire logic [16:0] divisor,
	output logic             done,
	output logic [16:0]      rem
);

	logic [30:0] num_q;
	logic [16:0] div_q;
	logic [16:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [17:0] trial;
	logic [17:0] rem_n;

	always_comb begin
		trial = {rem_q, num_q[30]};
		if (trial >= {1'b0, div_q}) begin
			rem_n = trial - {1'b0, div_q};
		end else begin
			rem_n = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[29:0], 1'b0};
			rem_q <= rem_n[16:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbei_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbei_ctrl - test sequencer
// Holds the generator state and error counters, runs the tests of one unit
// through the step and remainder units and hands each result on.
// ----------------------------------------------------------------------------
`default_nettype none

module rbei_ctrl #(
	parameter int MAX_UNIT_BYTES = 8192,
	parameter int MAX_TESTS      = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rbei_pkg::cfg_t       cfg,
	input  wire logic                 seed_load,
	input  wire logic [47:0]          seed,
	input  wire logic                 in_valid,
	input  wire logic [13:0]          unit_bytes,
	output logic                      in_ready,
	input  wire logic                 out_free,
	output logic                      res_load,
	output rbei_pkg::res_t            res
);

	localparam int TW = (MAX_TESTS > 1) ? $clog2(MAX_TESTS + 1) : 1;

	rbei_pkg::state_t state_q, state_n;

	logic [47:0]        lcg_q;
	logic [31:0]        units_q;
	logic [31:0]        flips_q;
	logic [TW-1:0]      tests_q;
	logic [TW-1:0]      test_q;
	logic [16:0]        divisor_q;
	logic               empty_q;
	logic               made_q;
	logic               flip_q;
	logic [12:0]        bidx_q;
	logic [7:0]         mask_q;

	logic               lcg_start, lcg_done;
	logic [47:0]        lcg_res;
	logic               mod_start, mod_done;
	logic [16:0]        mod_rem;

	logic [13:0]        bytes_sat;
	logic signed [18:0] zone;
	logic [TW-1:0]      tests_n;
	logic               hit;
	logic               last;
	logic [17:0]        bit_pos;
	logic [31:0]        units_n;
	logic [31:0]        flips_n;

	rbei_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lcg_start),
		.x      (lcg_q),
		.done   (lcg_done),
		.result (lcg_res)
	);

	rbei_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (lcg_res[47:17]),
		.divisor  (divisor_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		if ({3'b0, unit_bytes} > 17'(MAX_UNIT_BYTES)) begin
			bytes_sat = 14'(MAX_UNIT_BYTES);
		end else begin
			bytes_sat = unit_bytes;
		end
		zone = $signed({2'b0, bytes_sat, 3'b0}) - $signed({2'b0, cfg.header_bits})
			- $signed({2'b0, cfg.trailer_bits});

		if (cfg.max_errors == 5'd0) begin
			tests_n = TW'(1);
		end else if ({2'b0, cfg.max_errors} > 7'(MAX_TESTS)) begin
			tests_n = TW'(MAX_TESTS);
		end else begin
			tests_n = TW'(cfg.max_errors);
		end

		hit     = ({1'b0, lcg_res} <= cfg.error_threshold) && !empty_q;
		last    = (test_q == TW'(tests_q - TW'(1)));
		bit_pos = {1'b0, mod_rem} + {1'b0, cfg.header_bits};
		flips_n = flips_q + {31'b0, flip_q};
		units_n = units_q + {31'b0, flip_q && !made_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbei_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		in_ready  = 1'b0;
		lcg_start = 1'b0;
		mod_start = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			rbei_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_n = rbei_pkg::S_DRAW;
				end
			end
			rbei_pkg::S_DRAW: begin
				lcg_start = 1'b1;
				state_n   = rbei_pkg::S_DRAW_WAIT;
			end
			rbei_pkg::S_DRAW_WAIT: begin
				if (lcg_done) begin
					state_n = hit ? rbei_pkg::S_POS : rbei_pkg::S_EMIT;
				end
			end
			rbei_pkg::S_POS: begin
				lcg_start = 1'b1;
				state_n   = rbei_pkg::S_POS_WAIT;
			end
			rbei_pkg::S_POS_WAIT: begin
				if (lcg_done) begin
					mod_start = 1'b1;
					state_n   = rbei_pkg::S_MOD_WAIT;
				end
			end
			rbei_pkg::S_MOD_WAIT: begin
				if (mod_done) begin
					state_n = rbei_pkg::S_EMIT;
				end
			end
			rbei_pkg::S_EMIT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_n  = last ? rbei_pkg::S_IDLE : rbei_pkg::S_DRAW;
				end
			end
			default: state_n = rbei_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q   <= rbei_pkg::LCG_DEFAULT;
			units_q <= '0;
			flips_q <= '0;
			made_q  <= 1'b0;
			test_q  <= '0;
		end else begin
			if (seed_load) begin
				lcg_q <= seed;
			end else if (lcg_done) begin
				lcg_q <= lcg_res;
			end
			if (state_q == rbei_pkg::S_IDLE && in_valid) begin
				made_q <= 1'b0;
				test_q <= '0;
			end else if (res_load) begin
				units_q <= units_n;
				flips_q <= flips_n;
				made_q  <= made_q | flip_q;
				test_q  <= test_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rbei_pkg::S_IDLE && in_valid) begin
			tests_q   <= tests_n;
			divisor_q <= zone[16:0];
			empty_q   <= zone[18] || (zone == 19'sd0);
		end
		if (state_q == rbei_pkg::S_DRAW) begin
			flip_q <= 1'b0;
			bidx_q <= '0;
			mask_q <= '0;
		end else if (mod_done) begin
			flip_q <= 1'b1;
			bidx_q <= bit_pos[15:3];
			mask_q <= rbei_pkg::MASK_MSB >> bit_pos[2:0];
		end
	end

	always_comb begin
		res.flip          = flip_q;
		res.byte_index    = bidx_q;
		res.bit_mask      = mask_q;
		res.zone_empty    = empty_q;
		res.last_test     = last;
		res.errored_units = units_n;
		res.total_flips   = flips_n;
	end

	a_lcg_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_done |-> (state_q == rbei_pkg::S_DRAW_WAIT || state_q == rbei_pkg::S_POS_WAIT))
		else $error("generator step finished outside a wait state");

	a_mod_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == rbei_pkg::S_MOD_WAIT)
		else $error("remainder finished outside its wait state");

	a_flip_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.flip) |-> $onehot(res.bit_mask))
		else $error("flip without a single-bit mask");

	a_no_flip_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && !res.flip) |-> (res.bit_mask == 8'd0 && res.byte_index == 13'd0))
		else $error("non-flip result carries a position");

	a_empty_no_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.zone_empty) |-> !res.flip)
		else $error("flip made in an empty zone");

endmodule

`default_nettype wire

// ===== rtl/core/random_bit_error_injector.sv =====
// ----------------------------------------------------------------------------
// random_bit_error_injector - drand48 driven bit error position generator
// Per data unit, runs a number of error tests and reports the byte and XOR
// mask of each bit chosen for flipping, with running error counters.
//
//  port group  dir  payload
//  s_*         in   unit length in bytes
//  m_*         out  one result per test, tlast on the final test of a unit
//  p*          cfg  threshold, test count, header/trailer bits, seed
//
// Each test runs one generator step on the shared 24x32 multiplier; a hit test
// runs a second step for the bit position and then the serial remainder.
// s_tready is low while a unit is in progress; a stalled result holds the
// sequencer in its emit state. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module random_bit_error_injector #(
	parameter int MAX_UNIT_BYTES = 8192,
	parameter int MAX_TESTS      = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [13:0] unit_bytes
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // [12:0] byte_index, [20:13] bit_mask,
	                                    // [52:21] errored_units, [84:53] total_flips
	output logic [1:0]       m_tuser,   // [0] flip, [1] zone_empty
	output logic             m_tlast    // last_test
);

	rbei_pkg::cfg_t cfg_q;
	logic [47:0]    seed_q;
	logic           wr;
	logic [2:0]     reg_idx;
	logic           seed_load;

	rbei_pkg::res_t res;
	rbei_pkg::res_t out_q;
	logic           res_load;
	logic           m_tvalid_q;

	assign pready    = 1'b1;
	assign wr        = psel && penable && pwrite;
	assign reg_idx   = paddr[5:3];
	assign seed_load = wr && (reg_idx == rbei_pkg::REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_threshold <= '0;
			cfg_q.max_errors      <= 5'd1;
			cfg_q.header_bits     <= '0;
			cfg_q.trailer_bits    <= '0;
			seed_q                <= rbei_pkg::SEED_RESET;
		end else if (wr) begin
			unique case (reg_idx)
				rbei_pkg::REG_THRESHOLD:  cfg_q.error_threshold <= pwdata[48:0];
				rbei_pkg::REG_MAX_ERRORS: cfg_q.max_errors      <= pwdata[4:0];
				rbei_pkg::REG_HEADER:     cfg_q.header_bits     <= pwdata[16:0];
				rbei_pkg::REG_TRAILER:    cfg_q.trailer_bits    <= pwdata[16:0];
				rbei_pkg::REG_SEED:       seed_q                <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rbei_pkg::REG_THRESHOLD:  prdata = {15'b0, cfg_q.error_threshold};
			rbei_pkg::REG_MAX_ERRORS: prdata = {59'b0, cfg_q.max_errors};
			rbei_pkg::REG_HEADER:     prdata = {47'b0, cfg_q.header_bits};
			rbei_pkg::REG_TRAILER:    prdata = {47'b0, cfg_q.trailer_bits};
			rbei_pkg::REG_SEED:       prdata = {16'b0, seed_q};
			default:                  prdata = '0;
		endcase
	end

	rbei_ctrl #(
		.MAX_UNIT_BYTES (MAX_UNIT_BYTES),
		.MAX_TESTS      (MAX_TESTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.seed_load  (seed_load),
		.seed       (pwdata[47:0]),
		.in_valid   (s_tvalid),
		.unit_bytes (s_tdata[13:0]),
		.in_ready   (s_tready),
		.out_free   (!m_tvalid_q || m_tready),
		.res_load   (res_load),
		.res        (res)
	);

	// output register: result waits here while the next test runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b0, out_q.total_flips, out_q.errored_units, out_q.bit_mask,
		out_q.byte_index};
	assign m_tuser  = {out_q.zone_empty, out_q.flip};
	assign m_tlast  = out_q.last_test;

endmodule

`default_nettype wire
